### rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Both macros compile to nothing under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define QSM_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define QSM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	`QSM_ASSERT(label, clk, rst_n, (ante) |-> (cons))
`else
`define QSM_ASSERT(label, clk, rst_n, prop)
`define QSM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/qsm_pkg.sv
`timescale 1ns / 1ps
package qsm_pkg;

	localparam int unsigned ONE_Q15 = 32768;
	localparam int unsigned ANGLE_MAX = 25736;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;
		logic       capture;
		logic       issue;
		logic       round;
		logic       iter_init;
		logic       horner_step;
		logic       sqrt_step;
		logic [2:0] coef_idx;
		logic       finish;
	} qsm_cmd_t;

	// Q2.30 coefficients of the arc cosine polynomial, lowest degree first.
	function automatic logic signed [31:0] acos_coef(input logic [2:0] idx);
		logic signed [31:0] c;
		unique case (idx)
			3'd0: c = 32'sd1686629690;
			3'd1: c = -32'sd230423709;
			3'd2: c = 32'sd95540460;
			3'd3: c = -32'sd53874249;
			3'd4: c = 32'sd33169905;
			3'd5: c = -32'sd18348235;
			3'd6: c = 32'sd7161955;
			3'd7: c = -32'sd1355590;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

### rtl/qsm_ram.sv
`timescale 1ns / 1ps
module qsm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/qsm_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module qsm_ctrl #(
	parameter int MAX_SYMMETRIES = 64,
	parameter int AW = (MAX_SYMMETRIES > 1) ? $clog2(MAX_SYMMETRIES) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              operation,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [7:0]        cfg_data,
	input  logic              out_valid,
	input  logic              out_ready,
	output qsm_pkg::qsm_cmd_t cmd,
	output logic [AW-1:0]     raddr
);
	import qsm_pkg::*;

	localparam int CW = $clog2(MAX_SYMMETRIES + 1);
	localparam int ITERS = 16;
	localparam int HORNER_STEPS = 7;

	typedef enum logic [2:0] {
		ST_IDLE, ST_RUN, ST_DRAIN, ST_ROUND, ST_INIT, ST_ITER, ST_FINAL
	} state_t;

	state_t      state_q;
	logic [6:0]  count_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] cnt_q;
	logic [1:0]  dcnt_q;
	logic [3:0]  it_q;
	logic [CW-1:0] n_c;
	logic        accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign raddr = cnt_q[AW-1:0];

	// Entries used per measurement saturate at the table depth.
	always_comb begin
		if ({2'b00, count_q} > 9'(MAX_SYMMETRIES)) begin
			n_c = CW'(MAX_SYMMETRIES);
		end else begin
			n_c = CW'(count_q);
		end
	end

	// Command decode from the current state.
	always_comb begin
		cmd = '0;
		cmd.load = accept && !operation;
		cmd.capture = accept && operation;
		cmd.issue = (state_q == ST_RUN) && (n_q != '0);
		cmd.round = (state_q == ST_ROUND);
		cmd.iter_init = (state_q == ST_INIT);
		cmd.horner_step = (state_q == ST_ITER) && (it_q < 4'(HORNER_STEPS));
		cmd.sqrt_step = (state_q == ST_ITER);
		cmd.coef_idx = 3'(3'd6 - it_q[2:0]);
		cmd.finish = (state_q == ST_FINAL) && (!out_valid || out_ready);
	end

	// Sequencer and configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= 7'd1;
			n_q <= '0;
			cnt_q <= '0;
			dcnt_q <= '0;
			it_q <= '0;
		end else begin
			if (cfg_we && (cfg_index == 1'b0)) begin
				count_q <= cfg_data[6:0];
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && operation) begin
						n_q <= n_c;
						cnt_q <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if ((n_q == '0) || (cnt_q == n_q - 1'b1)) begin
						dcnt_q <= '0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == 2'd2) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: state_q <= ST_INIT;
				ST_INIT: begin
					it_q <= '0;
					state_q <= ST_ITER;
				end
				ST_ITER: begin
					it_q <= it_q + 1'b1;
					if (it_q == 4'(ITERS - 1)) begin
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					if (!out_valid || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`QSM_ASSERT_IMP(a_issue_in_range, clk, arst_n, cmd.issue, cnt_q < n_q)
	`QSM_ASSERT_IMP(a_finish_has_slot, clk, arst_n, cmd.finish, !out_valid || out_ready)
	`QSM_ASSERT_IMP(a_round_after_drain, clk, arst_n, state_q == ST_ROUND,
		$past(state_q) == ST_DRAIN)
endmodule

### rtl/qsm_datapath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module qsm_datapath #(
	parameter int MAX_SYMMETRIES = 64,
	parameter int COMPONENT_BITS = 16,
	parameter int AW = (MAX_SYMMETRIES > 1) ? $clog2(MAX_SYMMETRIES) : 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  qsm_pkg::qsm_cmd_t                cmd,
	input  logic [AW-1:0]                    raddr,
	input  logic [5:0]                       table_slot,
	input  logic signed [COMPONENT_BITS-1:0] first_w,
	input  logic signed [COMPONENT_BITS-1:0] first_x,
	input  logic signed [COMPONENT_BITS-1:0] first_y,
	input  logic signed [COMPONENT_BITS-1:0] first_z,
	input  logic signed [COMPONENT_BITS-1:0] second_w,
	input  logic signed [COMPONENT_BITS-1:0] second_x,
	input  logic signed [COMPONENT_BITS-1:0] second_y,
	input  logic signed [COMPONENT_BITS-1:0] second_z,
	input  logic                             cfg_we,
	input  logic                             cfg_index,
	input  logic [7:0]                       cfg_data,
	input  logic                             out_ready,
	output logic                             out_valid,
	output logic [14:0]                      angle,
	output logic [15:0]                      best_cosine,
	output logic                             invalid
);
	import qsm_pkg::*;

	localparam int C = COMPONENT_BITS;
	localparam int PW = 2 * C;
	localparam int WW = 2 * C + 2;
	localparam int MW = C + WW;
	localparam int DW = 3 * C + 4;
	localparam int SH = 3 * C - 18;
	localparam int BW = DW + 1 - SH;

	logic [7:0] tol_q;
	logic signed [C-1:0] b0_q, b1_q, b2_q, b3_q;
	logic signed [C-1:0] a0_q, a1_q, a2_q, a3_q;
	logic [4*C-1:0] rdata;
	logic [4*C-1:0] wdata;
	logic [8:0] slot_ext;
	logic ram_we;
	logic rv_q, v1_s1, v2_s2;
	logic signed [C-1:0] s0, s1, s2, s3;
	logic signed [PW-1:0] p00, p11, p22, p33, p10, p01, p32, p23;
	logic signed [PW-1:0] p20, p31, p02, p13, p30, p21, p12, p03;
	logic signed [WW-1:0] w_s1, x_s1, y_s1, z_s1;
	logic signed [MW-1:0] m0, m1, m2, m3;
	logic signed [DW-1:0] d_s2;
	logic [DW-1:0] mag;
	logic [DW-1:0] best_q;
	logic [DW:0] rsum;
	logic [BW-1:0] b15_q;
	logic [15:0] x_q;
	logic signed [33:0] p_q;
	logic signed [50:0] hp;
	logic signed [50:0] hs;
	logic [31:0] n_q, r_q, bit_q, rb;
	logic [32:0] pc;
	logic [49:0] fp;
	logic [49:0] fr;
	logic [14:0] acos_val;
	logic over, bad;
	logic [BW-1:0] excess;

	// Symmetry table store; loads outside the depth are dropped.
	assign slot_ext = {3'b000, table_slot};
	assign ram_we = cmd.load && (slot_ext < 9'(MAX_SYMMETRIES));
	assign wdata = {first_z, first_y, first_x, first_w};

	qsm_ram #(.WIDTH(4 * C), .DEPTH(MAX_SYMMETRIES), .AW(AW)) u_table (
		.clk(clk),
		.we(ram_we),
		.waddr(slot_ext[AW-1:0]),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign s0 = rdata[C-1:0];
	assign s1 = rdata[2*C-1:C];
	assign s2 = rdata[3*C-1:2*C];
	assign s3 = rdata[4*C-1:3*C];

	// Hamilton product of the second quaternion with the table entry.
	assign p00 = a0_q * s0;
	assign p11 = a1_q * s1;
	assign p22 = a2_q * s2;
	assign p33 = a3_q * s3;
	assign p10 = a1_q * s0;
	assign p01 = a0_q * s1;
	assign p32 = a3_q * s2;
	assign p23 = a2_q * s3;
	assign p20 = a2_q * s0;
	assign p31 = a3_q * s1;
	assign p02 = a0_q * s2;
	assign p13 = a1_q * s3;
	assign p30 = a3_q * s0;
	assign p21 = a2_q * s1;
	assign p12 = a1_q * s2;
	assign p03 = a0_q * s3;

	// Dot with the first quaternion and magnitude of the result.
	assign m0 = b0_q * w_s1;
	assign m1 = b1_q * x_s1;
	assign m2 = b2_q * y_s1;
	assign m3 = b3_q * z_s1;
	assign mag = (d_s2 < 0) ? DW'(-d_s2) : DW'(d_s2);

	// Round half up into Q1.15.
	assign rsum = {1'b0, best_q} + (DW + 1)'(1) * ((DW + 1)'(1) << (SH - 1));

	// Polynomial step and square root step.
	assign hp = p_q * $signed({1'b0, x_q});
	assign hs = hp >>> 15;
	assign rb = r_q + bit_q;

	// Final scaling of polynomial times root.
	assign pc = p_q[33] ? 33'd0 : p_q[32:0];
	assign fp = pc * r_q[16:0];
	assign fr = (fp + (50'd1 << 30)) >> 31;
	assign acos_val = (fr > 50'(ANGLE_MAX)) ? 15'(ANGLE_MAX) : fr[14:0];
	assign over = b15_q > BW'(ONE_Q15);
	assign excess = b15_q - BW'(ONE_Q15);
	assign bad = over && (excess > BW'(tol_q));

	// Operand capture and the per-entry pipeline.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			b0_q <= first_w;
			b1_q <= first_x;
			b2_q <= first_y;
			b3_q <= first_z;
			a0_q <= second_w;
			a1_q <= second_x;
			a2_q <= second_y;
			a3_q <= second_z;
		end
		w_s1 <= WW'(p00) - WW'(p11) - WW'(p22) - WW'(p33);
		x_s1 <= WW'(p10) + WW'(p01) - WW'(p32) + WW'(p23);
		y_s1 <= WW'(p20) + WW'(p31) + WW'(p02) - WW'(p13);
		z_s1 <= WW'(p30) - WW'(p21) + WW'(p12) + WW'(p03);
		d_s2 <= DW'(m0) + DW'(m1) + DW'(m2) + DW'(m3);
		if (cmd.capture) begin
			best_q <= '0;
		end else if (v2_s2 && (mag > best_q)) begin
			best_q <= mag;
		end
		if (cmd.round) begin
			b15_q <= rsum[DW:SH];
			if (rsum[DW:SH] > BW'(ONE_Q15)) begin
				x_q <= 16'(ONE_Q15);
			end else begin
				x_q <= rsum[SH+15:SH];
			end
		end
		if (cmd.iter_init) begin
			p_q <= 34'(acos_coef(3'd7));
			n_q <= 32'(17'(ONE_Q15) - {1'b0, x_q}) << 15;
			r_q <= '0;
			bit_q <= 32'd1 << 30;
		end else begin
			if (cmd.horner_step) begin
				p_q <= hs[33:0] + 34'(acos_coef(cmd.coef_idx));
			end
			if (cmd.sqrt_step) begin
				if (n_q >= rb) begin
					n_q <= n_q - rb;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
		end
		if (cmd.finish) begin
			angle <= over ? 15'd0 : acos_val;
			best_cosine <= (b15_q > BW'(16'hFFFF)) ? 16'hFFFF : b15_q[15:0];
			invalid <= bad;
		end
	end

	// Control state: pipeline tags, output flag, tolerance register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q <= 1'b0;
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			out_valid <= 1'b0;
			tol_q <= 8'd4;
		end else begin
			rv_q <= cmd.issue;
			v1_s1 <= rv_q;
			v2_s2 <= v1_s1;
			if (cmd.finish) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (cfg_we && (cfg_index == 1'b1)) begin
				tol_q <= cfg_data;
			end
		end
	end

	`QSM_ASSERT_IMP(a_angle_range, clk, arst_n, out_valid, angle <= 15'(ANGLE_MAX))
	`QSM_ASSERT_IMP(a_invalid_zero, clk, arst_n, out_valid && invalid, angle == 15'd0)
	`QSM_ASSERT_IMP(a_rise_from_finish, clk, arst_n, $rose(out_valid), $past(cmd.finish))
endmodule

### rtl/quaternion_symmetric_misorientation.sv
`timescale 1ns / 1ps
// Symmetry-reduced misorientation angle between two unit quaternions.
// Input channel (in_valid/in_ready): a beat with operation 0 writes first_*
// into symmetry table slot table_slot; a beat with operation 1 measures
// first_* against second_* under the first symmetry_count table entries.
// Output channel (out_valid/out_ready): one beat per measurement carrying
// angle (Q3.13 radians), best_cosine (Q1.15) and invalid.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 symmetry
// count, 1 overshoot tolerance) in the same cycle.
// Load beats leave the block idle and ready for the next beat. A measurement
// reads one table entry per cycle for each entry in use through a
// three-stage product and dot pipeline, then rounds the best cosine and
// runs a shared loop for the square root and arc cosine polynomial.
// A new beat is accepted once the previous measurement has reached the
// output register, so results may wait there while the next one runs.
// If the receiver stalls with a result still held, the block waits before
// writing the next one. Reset clears control state and sets the count to 1
// and the tolerance to 4; table contents are undefined until loaded.
module quaternion_symmetric_misorientation #(
	parameter int MAX_SYMMETRIES = 64,
	parameter int COMPONENT_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             operation,
	input  logic [5:0]                       table_slot,
	input  logic signed [COMPONENT_BITS-1:0] first_w,
	input  logic signed [COMPONENT_BITS-1:0] first_x,
	input  logic signed [COMPONENT_BITS-1:0] first_y,
	input  logic signed [COMPONENT_BITS-1:0] first_z,
	input  logic signed [COMPONENT_BITS-1:0] second_w,
	input  logic signed [COMPONENT_BITS-1:0] second_x,
	input  logic signed [COMPONENT_BITS-1:0] second_y,
	input  logic signed [COMPONENT_BITS-1:0] second_z,
	input  logic                             cfg_we,
	input  logic                             cfg_index,
	input  logic [7:0]                       cfg_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [14:0]                      angle,
	output logic [15:0]                      best_cosine,
	output logic                             invalid
);
	import qsm_pkg::*;

	localparam int AW = (MAX_SYMMETRIES > 1) ? $clog2(MAX_SYMMETRIES) : 1;

	qsm_cmd_t      cmd;
	logic [AW-1:0] raddr;

	qsm_ctrl #(.MAX_SYMMETRIES(MAX_SYMMETRIES), .AW(AW)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd(cmd),
		.raddr(raddr)
	);

	qsm_datapath #(
		.MAX_SYMMETRIES(MAX_SYMMETRIES),
		.COMPONENT_BITS(COMPONENT_BITS),
		.AW(AW)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.raddr(raddr),
		.table_slot(table_slot),
		.first_w(first_w),
		.first_x(first_x),
		.first_y(first_y),
		.first_z(first_z),
		.second_w(second_w),
		.second_x(second_x),
		.second_y(second_y),
		.second_z(second_z),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.angle(angle),
		.best_cosine(best_cosine),
		.invalid(invalid)
	);
endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
	import qsm_pkg::*;

	localparam bit OP_LOAD = 1'b0;
	localparam bit OP_MEASURE = 1'b1;
	localparam bit REG_COUNT = 1'b0;
	localparam bit REG_TOLERANCE = 1'b1;
	localparam int TABLE_DEPTH = 64;
	localparam int DRAIN_CYCLES = 100;

	typedef enum logic [1:0] {ROW_LOAD, ROW_MEASURE, ROW_CONFIG} row_kind_t;

	typedef struct packed {
		logic [14:0] angle;
		logic [15:0] cosine;
		logic        invalid;
	} angle_result_t;

	typedef struct {
		row_kind_t     kind;
		logic [5:0]    slot;
		logic [15:0]   q1 [4];
		logic [15:0]   q2 [4];
		logic          reg_index;
		logic [7:0]    reg_value;
		bit            typed;
		angle_result_t typed_result;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic operation = 1'b0;
	logic [5:0] table_slot = '0;
	logic signed [15:0] first_w = '0, first_x = '0, first_y = '0, first_z = '0;
	logic signed [15:0] second_w = '0, second_x = '0, second_y = '0, second_z = '0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [7:0] cfg_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [14:0] angle;
	logic [15:0] best_cosine;
	logic invalid;
	int stall_left = 0;

	// Shadow of the block state.
	logic signed [15:0] sym_shadow [TABLE_DEPTH][4];
	logic [6:0] count_shadow;
	logic [7:0] tolerance_shadow;
	angle_result_t pending_angles [$];
	bit failed = 1'b0;

	longint acos_poly [8] = '{1686629690, -230423709, 95540460, -53874249,
		33169905, -18348235, 7161955, -1355590};

	quaternion_symmetric_misorientation i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .table_slot(table_slot),
		.first_w(first_w), .first_x(first_x), .first_y(first_y), .first_z(first_z),
		.second_w(second_w), .second_x(second_x), .second_y(second_y),
		.second_z(second_z),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.angle(angle), .best_cosine(best_cosine), .invalid(invalid)
	);

	always #1 clk = ~clk;

	// Run limit.
	initial begin
		#5000000;
		$display("quaternion_symmetric_misorientation: mismatch");
		$finish;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Floor square root.
	function automatic longint unsigned floor_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Twice the arc cosine of a Q1.15 cosine, in Q3.13.
	function automatic longint unsigned twice_acos(longint unsigned x);
		longint p;
		longint unsigned root, prod;
		if (x > ONE_Q15) x = ONE_Q15;
		p = acos_poly[7];
		for (int k = 6; k >= 0; k--)
			p = ((p * longint'(x)) >>> 15) + acos_poly[k];
		if (p < 0) p = 0;
		root = floor_sqrt((ONE_Q15 - x) << 15);
		prod = (longint'(p) * root + (64'd1 << 30)) >> 31;
		return (prod > ANGLE_MAX) ? ANGLE_MAX : prod;
	endfunction

	// Best symmetric cosine and angle for one measurement.
	function automatic angle_result_t predict_angle(logic signed [15:0] q1 [4],
			logic signed [15:0] q2 [4]);
		longint a [4], b [4], s [4], w, x, y, z, d;
		longint unsigned best, mag, cos15;
		int n;
		angle_result_t res;
		best = 0;
		for (int k = 0; k < 4; k++) begin
			b[k] = q1[k];
			a[k] = q2[k];
		end
		n = (count_shadow > TABLE_DEPTH) ? TABLE_DEPTH : count_shadow;
		for (int i = 0; i < n; i++) begin
			for (int k = 0; k < 4; k++) s[k] = sym_shadow[i][k];
			w = a[0] * s[0] - a[1] * s[1] - a[2] * s[2] - a[3] * s[3];
			x = a[1] * s[0] + a[0] * s[1] - a[3] * s[2] + a[2] * s[3];
			y = a[2] * s[0] + a[3] * s[1] + a[0] * s[2] - a[1] * s[3];
			z = a[3] * s[0] - a[2] * s[1] + a[1] * s[2] + a[0] * s[3];
			d = b[0] * w + b[1] * x + b[2] * y + b[3] * z;
			mag = (d < 0) ? -d : d;
			if (mag > best) best = mag;
		end
		cos15 = (best + (64'd1 << 29)) >> 30;
		res.invalid = 1'b0;
		res.angle = '0;
		if (cos15 <= ONE_Q15)
			res.angle = 15'(twice_acos(cos15));
		else if (cos15 - ONE_Q15 > tolerance_shadow)
			res.invalid = 1'b1;
		res.cosine = (cos15 > 16'hFFFF) ? 16'hFFFF : 16'(cos15);
		return res;
	endfunction

	// Send one beat and update the shadow once it is taken.
	task automatic send_beat(stim_row_t row);
		int gap;
		logic signed [15:0] q1 [4], q2 [4];
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= (row.kind == ROW_MEASURE) ? OP_MEASURE : OP_LOAD;
		table_slot <= row.slot;
		{first_w, first_x, first_y, first_z} <= {row.q1[0], row.q1[1], row.q1[2], row.q1[3]};
		{second_w, second_x, second_y, second_z} <=
			{row.q2[0], row.q2[1], row.q2[2], row.q2[3]};
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		for (int k = 0; k < 4; k++) begin
			q1[k] = row.q1[k];
			q2[k] = row.q2[k];
		end
		if (row.kind == ROW_LOAD) begin
			for (int k = 0; k < 4; k++) sym_shadow[row.slot][k] = q1[k];
		end else if (row.typed) begin
			pending_angles.push_back(row.typed_result);
		end else begin
			pending_angles.push_back(predict_angle(q1, q2));
		end
	endtask

	// Register write once every measurement has drained.
	task automatic write_register(logic idx, logic [7:0] value);
		in_valid <= 1'b0;
		while (pending_angles.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_COUNT) count_shadow = value[6:0];
		else tolerance_shadow = value;
	endtask

	task automatic run_row(stim_row_t row);
		if (row.kind == ROW_CONFIG) write_register(row.reg_index, row.reg_value);
		else send_beat(row);
	endtask

	function automatic stim_row_t make_row(row_kind_t kind, logic [5:0] slot,
			logic [63:0] q1, logic [63:0] q2);
		stim_row_t r;
		r.kind = kind;
		r.slot = slot;
		for (int k = 0; k < 4; k++) begin
			r.q1[k] = q1[63 - 16*k -: 16];
			r.q2[k] = q2[63 - 16*k -: 16];
		end
		r.reg_index = REG_COUNT;
		r.reg_value = '0;
		r.typed = 1'b0;
		r.typed_result = '0;
		return r;
	endfunction

	function automatic stim_row_t make_config(logic idx, logic [7:0] value);
		stim_row_t r;
		r = make_row(ROW_CONFIG, '0, '0, '0);
		r.reg_index = idx;
		r.reg_value = value;
		return r;
	endfunction

	function automatic stim_row_t make_typed(logic [63:0] q1, logic [63:0] q2,
			angle_result_t res);
		stim_row_t r;
		r = make_row(ROW_MEASURE, '0, q1, q2);
		r.typed = 1'b1;
		r.typed_result = res;
		return r;
	endfunction

	// Random quaternion: full range, or near unit with noise.
	function automatic logic [63:0] random_quat();
		logic [63:0] q;
		if ($urandom_range(0, 2) == 0) return {$urandom, $urandom};
		q = '0;
		for (int k = 0; k < 4; k++)
			q[63 - 16*k -: 16] = 16'($signed($urandom_range(0, 400)) - 200);
		q[63 - 16*$urandom_range(0, 3) -: 16] =
			$urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
		return q;
	endfunction

	localparam logic [63:0] NEG_W = {16'h8000, 48'h0};
	localparam logic [63:0] NEG_ALL = {4{16'h8000}};
	localparam logic [63:0] UNIT_W = {16'h7FFF, 48'h0};
	localparam logic [63:0] NEAR_WX = {16'hBFFE, 16'hBFFE, 32'h0};
	localparam logic [63:0] NEG_WX = {16'h8000, 16'h8000, 32'h0};

	// Directed part and random phases.
	initial begin
		stim_row_t directed [$];
		stim_row_t row;
		logic [63:0] qa;
		logic [7:0] count_picks [6] = '{8'd0, 8'd1, 8'd64, 8'd127, 8'd255, 8'd8};
		logic [7:0] tol_picks [4] = '{8'd0, 8'd255, 8'd4, 8'd17};

		count_shadow = 7'd1;
		tolerance_shadow = 8'd4;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every slot gets an entry before any count above one is used.
		for (int i = 0; i < TABLE_DEPTH; i++)
			send_beat(make_row(ROW_LOAD, 6'(i), random_quat(), {$urandom, $urandom}));

		directed.push_back(make_row(ROW_LOAD, 6'd0, NEG_W, '0));
		directed.push_back(make_typed(NEG_W, NEG_W, '{15'd0, 16'd32768, 1'b0}));
		directed.push_back(make_row(ROW_LOAD, 6'd0, NEG_ALL, '0));
		directed.push_back(make_typed(NEG_ALL, NEG_ALL, '{15'd0, 16'hFFFF, 1'b1}));
		directed.push_back(make_config(REG_COUNT, 8'd0));
		directed.push_back(make_typed(NEG_ALL, UNIT_W, '{15'(ANGLE_MAX), 16'd0, 1'b0}));
		directed.push_back(make_config(REG_COUNT, 8'd1));
		directed.push_back(make_row(ROW_LOAD, 6'd0, UNIT_W, {4{16'h7FFF}}));
		// Overshoot inside the tolerance, then with none allowed.
		directed.push_back(make_row(ROW_MEASURE, '0, NEAR_WX, NEG_WX));
		directed.push_back(make_config(REG_TOLERANCE, 8'd0));
		directed.push_back(make_row(ROW_MEASURE, '0, NEAR_WX, NEG_WX));
		directed.push_back(make_row(ROW_MEASURE, '0, {4{16'h7FFF}}, {4{16'h7FFF}}));
		directed.push_back(make_row(ROW_MEASURE, '0, UNIT_W, {16'h0, 16'h7FFF, 32'h0}));
		directed.push_back(make_row(ROW_LOAD, 6'd63, {4{16'h7FFF}}, '0));
		// Count beyond the table depth saturates.
		directed.push_back(make_config(REG_COUNT, 8'd127));
		directed.push_back(make_row(ROW_MEASURE, '0, {4{16'h7FFF}}, UNIT_W));
		directed.push_back(make_row(ROW_MEASURE, '0, NEG_ALL, {4{16'h7FFF}}));
		directed.push_back(make_config(REG_TOLERANCE, 8'd255));
		directed.push_back(make_row(ROW_MEASURE, '0, NEAR_WX, NEG_WX));
		foreach (directed[i]) run_row(directed[i]);

		// Random phases, each under its own register setting.
		for (int phase = 0; phase < 6; phase++) begin
			write_register(REG_COUNT, (phase < 6) ? count_picks[phase] : 8'($urandom));
			write_register(REG_TOLERANCE, tol_picks[phase % 4]);
			for (int i = 0; i < 200; i++) begin
				qa = random_quat();
				if ($urandom_range(0, 3) == 0) begin
					row = make_row(ROW_LOAD, 6'($urandom), random_quat(),
						{$urandom, $urandom});
				end else if ($urandom_range(0, 1) == 0) begin
					// Same orientation twice.
					row = make_row(ROW_MEASURE, '0, qa, qa);
				end else begin
					row = make_row(ROW_MEASURE, '0, qa, random_quat());
				end
				send_beat(row);
			end
		end

		in_valid <= 1'b0;
		while (pending_angles.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!failed) begin
			$display("quaternion_symmetric_misorientation: match");
		end else begin
			$display("quaternion_symmetric_misorientation: mismatch");
		end
		$finish;
	end

	// Receiver stalls: after each ready cycle a gap of random length.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			stall_left <= pick_gap();
			out_ready <= 1'b1;
		end
	end

	// Result beats are compared mid-cycle, ahead of the edge that takes them.
	always @(negedge clk) begin
		angle_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_angles.size() == 0) begin
				$error("unexpected result beat");
				failed = 1'b1;
			end else begin
				want = pending_angles.pop_front();
				if (angle !== want.angle) begin
					$error("angle: expected %0d, actual %0d", want.angle, angle);
					failed = 1'b1;
				end
				if (best_cosine !== want.cosine) begin
					$error("best_cosine: expected %0d, actual %0d", want.cosine, best_cosine);
					failed = 1'b1;
				end
				if (invalid !== want.invalid) begin
					$error("invalid: expected %0d, actual %0d", want.invalid, invalid);
					failed = 1'b1;
				end
			end
		end
	end

endmodule
